// ----- hdl/hlmdb_pkg.sv -----
// Package for the hemisphere lidar min-depth binner.
// Holds widths, register indexes, CORDIC angle table, sequencer states and unit result structs.
// No dependencies.
package hlmdb_pkg;

  localparam int COORD_W      = 20;
  localparam int OFF_W        = 13;
  localparam int LIM_W        = 12;
  localparam int DIFF_W       = 22;
  localparam int ANG_W        = 26;
  localparam int PROD_W       = 2 * ANG_W;
  localparam int SUM_W        = 42;
  localparam int SQ_W         = 44;
  localparam int ROOT_W       = SQ_W / 2;
  localparam int REM_W        = ROOT_W + 1;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;

  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(8388608);
  localparam logic signed [ANG_W-1:0] POLAR_MAX = ANG_W'(3728270);
  localparam logic [LIM_W-1:0]        FAR_RESET = LIM_W'(2500);

  // Register indexes on the configuration port
  localparam logic [2:0] REG_FRONT_X = 3'd0;
  localparam logic [2:0] REG_FRONT_Y = 3'd1;
  localparam logic [2:0] REG_FRONT_Z = 3'd2;
  localparam logic [2:0] REG_REAR_X  = 3'd3;
  localparam logic [2:0] REG_REAR_Y  = 3'd4;
  localparam logic [2:0] REG_REAR_Z  = 3'd5;
  localparam logic [2:0] REG_NEAR    = 3'd6;
  localparam logic [2:0] REG_FAR     = 3'd7;

  // atan(2^-i) in units of 2^-24 turn
  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860, 10430,
    5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } sqrt_res_t;

  typedef struct packed {
    logic                    done;
    logic signed [ANG_W-1:0] ang;
  } cordic_res_t;

  typedef enum logic [18:0] {
    S_CLEAR  = 19'h00001,
    S_IDLE   = 19'h00002,
    S_MUL_X  = 19'h00004,
    S_MUL_Y  = 19'h00008,
    S_MUL_Z  = 19'h00010,
    S_MUL_N  = 19'h00020,
    S_MUL_F  = 19'h00040,
    S_CHECK  = 19'h00080,
    S_SQRT_R = 19'h00100,
    S_SQRT_P = 19'h00200,
    S_CORD_P = 19'h00400,
    S_CORD_A = 19'h00800,
    S_IDX_P  = 19'h01000,
    S_IDX_A  = 19'h02000,
    S_IDX_C  = 19'h04000,
    S_MEM_RD = 19'h08000,
    S_MEM_WR = 19'h10000,
    S_RD_REQ = 19'h20000,
    S_RD_OUT = 19'h40000
  } state_e;

endpackage

// ----- hdl/hlmdb_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on hlmdb_pkg for operand widths.
module hlmdb_mul import hlmdb_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [ANG_W-1:0]  a_i,
  input  logic signed [ANG_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- hdl/hlmdb_sqrt.sv -----
// Bit-serial integer square root, two radicand bits per cycle, with remainder.
// Depends on hlmdb_pkg for widths and the result struct.
module hlmdb_sqrt import hlmdb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SQ_W-1:0] op_i,
  output sqrt_res_t       res_o
);

  logic            busy_q, done_q;
  logic [SQ_W-1:0] v_q, r_q, bit_q;
  logic [SQ_W-1:0] trial;
  logic            take;

  assign trial = r_q + bit_q;
  assign take  = (v_q >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      busy_q <= !bit_q[0];
      done_q <= bit_q[0];
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= op_i;
      r_q   <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_q) begin
      if (take) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign res_o.done = done_q;
  assign res_o.root = r_q[ROOT_W-1:0];
  assign res_o.rem  = v_q[REM_W-1:0];

endmodule

// ----- hdl/hlmdb_cordic.sv -----
// Vectoring CORDIC atan2, one micro-rotation per cycle, angle in 2^-24 turn.
// Depends on hlmdb_pkg for the angle table, widths and the result struct.
module hlmdb_cordic import hlmdb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ANG_W-1:0] x_i,
  input  logic signed [ANG_W-1:0] y_i,
  output cordic_res_t             res_o
);

  logic                    busy_q, done_q;
  logic [STEP_W-1:0]       i_q;
  logic signed [ANG_W-1:0] x_q, y_q, ang_q;
  logic signed [ANG_W-1:0] dx, dy, step_ang;
  logic                    last_step;

  assign dx        = y_q >>> i_q;
  assign dy        = x_q >>> i_q;
  assign step_ang  = ANG_W'(ATAN_TAB[i_q]);
  assign last_step = (i_q == STEP_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      // a zero y settles at once
      busy_q <= (y_i != '0);
      done_q <= (y_i == '0);
    end else if (busy_q) begin
      busy_q <= !last_step;
      done_q <= last_step;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      i_q <= '0;
      if (y_i == '0) begin
        ang_q <= (x_i < 0) ? HALF_TURN : '0;
        x_q   <= x_i;
        y_q   <= y_i;
      end else if (x_i < 0) begin
        // fold the left half-plane onto the right
        ang_q <= (y_i > 0) ? HALF_TURN : -HALF_TURN;
        x_q   <= -x_i;
        y_q   <= -y_i;
      end else begin
        ang_q <= '0;
        x_q   <= x_i;
        y_q   <= y_i;
      end
    end else if (busy_q) begin
      i_q <= i_q + STEP_W'(1);
      if (y_q >= 0) begin
        x_q   <= x_q + dx;
        y_q   <= y_q - dy;
        ang_q <= ang_q + step_ang;
      end else begin
        x_q   <= x_q - dx;
        y_q   <= y_q + dy;
        ang_q <= ang_q - step_ang;
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.ang  = ang_q;

endmodule

// ----- hdl/hemisphere_lidar_min_depth_binner.sv -----
// Top level of the hemisphere lidar min-depth binner: sequencer, bin memory, registers.
// Depends on hlmdb_pkg, hlmdb_mul, hlmdb_sqrt and hlmdb_cordic.
//
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+-----------------------------
//  command   | func_i, x_mm_i, y_mm_i, z_mm_i               | transfer on start & !busy
//  result    | bin_index_o, depth_mm_o, last_o              | done_o, one cycle, no stall
//  config    | cfg_idx_i, cfg_wdata_i                       | cfg_we_i, written at once
//
// A readout command keeps busy high through S_RD_REQ and S_RD_OUT; its result shows in the cycle after S_RD_OUT.
// An accumulate command runs, per hemisphere that bins the point, the shared multiplier
// passes, two square roots, two CORDIC runs, then indexing and memory; a hemisphere whose
// range check drops it stops there, and one past the polar limit after the first CORDIC run.
// After reset a clearing pass writes all 2*POLAR_BINS*AZIMUTH_BINS bins with busy high;
// configuration writes are taken throughout.
module hemisphere_lidar_min_depth_binner import hlmdb_pkg::*; #(
  parameter int POLAR_BINS   = 16,
  parameter int AZIMUTH_BINS = 31
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      func_i,
  input  logic signed [COORD_W-1:0] x_mm_i,
  input  logic signed [COORD_W-1:0] y_mm_i,
  input  logic signed [COORD_W-1:0] z_mm_i,
  output logic                      done_o,
  output logic [9:0]                bin_index_o,
  output logic [LIM_W-1:0]          depth_mm_o,
  output logic                      last_o,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [OFF_W-1:0]          cfg_wdata_i
);

  localparam int CELLS  = POLAR_BINS * AZIMUTH_BINS;
  localparam int TOTAL  = 2 * CELLS;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int PI_W   = $clog2(POLAR_BINS);
  localparam int AI_W   = $clog2(AZIMUTH_BINS);
  localparam int POL_K  = 9 * (POLAR_BINS - 1);
  localparam int AZ_K   = AZIMUTH_BINS - 1;

  // configuration registers
  logic signed [OFF_W-1:0] off_fx_q, off_fy_q, off_fz_q, off_rx_q, off_ry_q, off_rz_q;
  logic [LIM_W-1:0]        near_q, far_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_fx_q <= OFF_W'(320);
      off_fy_q <= '0;
      off_fz_q <= -OFF_W'(13);
      off_rx_q <= -OFF_W'(320);
      off_ry_q <= '0;
      off_rz_q <= -OFF_W'(13);
      near_q   <= LIM_W'(300);
      far_q    <= FAR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRONT_X: off_fx_q <= cfg_wdata_i;
        REG_FRONT_Y: off_fy_q <= cfg_wdata_i;
        REG_FRONT_Z: off_fz_q <= cfg_wdata_i;
        REG_REAR_X:  off_rx_q <= cfg_wdata_i;
        REG_REAR_Y:  off_ry_q <= cfg_wdata_i;
        REG_REAR_Z:  off_rz_q <= cfg_wdata_i;
        REG_NEAR:    near_q   <= cfg_wdata_i[LIM_W-1:0];
        REG_FAR:     far_q    <= cfg_wdata_i[LIM_W-1:0];
      endcase
    end
  end

  state_e state_q, state_d;
  logic   accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // point relative to each sensor origin
  logic signed [DIFF_W-1:0] fx, fy, fz, bx, by, bz;

  assign fx = DIFF_W'(x_mm_i) - DIFF_W'(off_fx_q);
  assign fy = DIFF_W'(y_mm_i) - DIFF_W'(off_fy_q);
  assign fz = DIFF_W'(z_mm_i) - DIFF_W'(off_fz_q);
  assign bx = DIFF_W'(x_mm_i) - DIFF_W'(off_rx_q);
  assign by = DIFF_W'(y_mm_i) - DIFF_W'(off_ry_q);
  assign bz = DIFF_W'(z_mm_i) - DIFF_W'(off_rz_q);

  // working registers
  logic signed [DIFF_W-1:0] ax_q, ay_q, az_q, rear_x_q, rear_y_q, rear_z_q;
  logic                     hemi_q, rear_pend_q;
  logic [SUM_W-1:0]         s_q, ps_q;
  logic [LIM_W*2-1:0]       lim_q;
  logic [LIM_W-1:0]         range_q;
  logic [ANG_W-1:0]         polar_q, azim_q;
  logic [PI_W-1:0]          pi_q;
  logic [ADDR_W-1:0]        addr_q, ptr_q, clr_q;
  logic [LIM_W-1:0]         rdata_q;

  // shared units
  logic signed [ANG_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     sq_start, cd_start;
  logic [SQ_W-1:0]          sq_op;
  logic signed [ANG_W-1:0]  cd_x, cd_y;
  sqrt_res_t                sq_res;
  cordic_res_t              cd_res;

  hlmdb_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  hlmdb_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .op_i    (sq_op),
    .res_o   (sq_res)
  );

  hlmdb_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cd_start),
    .x_i     (cd_x),
    .y_i     (cd_y),
    .res_o   (cd_res)
  );

  // datapath values
  logic [SUM_W-1:0]         prod_lo;
  logic                     in_range, range_up, polar_ok;
  logic signed [ANG_W-1:0]  azim_sum;
  logic signed [PROD_W-1:0] pi_sum, ai_sum;
  logic [PI_W-1:0]          pi_d;
  logic [AI_W-1:0]          ai_d;
  logic [ADDR_W-1:0]        addr_d;
  logic [LIM_W-1:0]         rd_depth;

  assign prod_lo  = prod[SUM_W-1:0];
  assign in_range = (s_q >= SUM_W'(lim_q)) && (s_q <= SUM_W'(prod[LIM_W*2-1:0]));
  assign range_up = (sq_res.rem > REM_W'(sq_res.root));
  assign polar_ok = (cd_res.ang <= POLAR_MAX);
  assign azim_sum = cd_res.ang + HALF_TURN;
  assign pi_sum   = prod + PROD_W'(1 << 24);
  assign ai_sum   = prod + PROD_W'(1 << 23);
  assign rd_depth = (rdata_q < near_q) ? far_q : rdata_q;

  always_comb begin
    pi_d = (pi_sum[PROD_W-1:25] > (PROD_W-25)'(POLAR_BINS - 1))
           ? PI_W'(POLAR_BINS - 1) : pi_sum[PI_W+24:25];
    ai_d = (ai_sum[PROD_W-1:24] > (PROD_W-24)'(AZIMUTH_BINS - 1))
           ? AI_W'(AZIMUTH_BINS - 1) : ai_sum[AI_W+23:24];
    addr_d = (hemi_q ? ADDR_W'(CELLS) : '0)
           + ADDR_W'(pi_q) * ADDR_W'(AZIMUTH_BINS) + ADDR_W'(ai_d);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MUL_X: begin mul_a = ANG_W'(ax_q); mul_b = ANG_W'(ax_q); end
      S_MUL_Y: begin mul_a = ANG_W'(ay_q); mul_b = ANG_W'(ay_q); end
      S_MUL_Z: begin mul_a = ANG_W'(az_q); mul_b = ANG_W'(az_q); end
      S_MUL_N: begin mul_a = $signed(ANG_W'(near_q)); mul_b = $signed(ANG_W'(near_q)); end
      S_MUL_F: begin mul_a = $signed(ANG_W'(far_q)); mul_b = $signed(ANG_W'(far_q)); end
      S_IDX_P: begin mul_a = $signed(polar_q); mul_b = ANG_W'(POL_K); end
      S_IDX_A: begin mul_a = $signed(azim_q); mul_b = ANG_W'(AZ_K); end
      default: ;
    endcase
  end

  // sequencer
  logic hemi_end, load_front, load_rear_acc, load_rear;

  always_comb begin
    state_d       = state_q;
    hemi_end      = 1'b0;
    load_front    = 1'b0;
    load_rear_acc = 1'b0;
    load_rear     = 1'b0;
    sq_start      = 1'b0;
    sq_op         = SQ_W'(s_q);
    cd_start      = 1'b0;
    cd_x          = {ax_q[15:0], 10'd0};
    cd_y          = $signed(ANG_W'(sq_res.root));
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == ADDR_W'(TOTAL - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (func_i) begin
            state_d = S_RD_REQ;
          end else if (fx > 0) begin
            load_front = 1'b1;
            state_d    = S_MUL_X;
          end else if (bx < 0) begin
            load_rear_acc = 1'b1;
            state_d       = S_MUL_X;
          end
        end
      end
      S_MUL_X: state_d = S_MUL_Y;
      S_MUL_Y: state_d = S_MUL_Z;
      S_MUL_Z: state_d = S_MUL_N;
      S_MUL_N: state_d = S_MUL_F;
      S_MUL_F: state_d = S_CHECK;
      S_CHECK: begin
        if (in_range) begin
          sq_start = 1'b1;
          state_d  = S_SQRT_R;
        end else begin
          hemi_end = 1'b1;
        end
      end
      S_SQRT_R: begin
        if (sq_res.done) begin
          sq_start = 1'b1;
          sq_op    = {ps_q[23:0], 20'd0};
          state_d  = S_SQRT_P;
        end
      end
      S_SQRT_P: begin
        if (sq_res.done) begin
          cd_start = 1'b1;
          state_d  = S_CORD_P;
        end
      end
      S_CORD_P: begin
        if (cd_res.done) begin
          if (polar_ok) begin
            cd_start = 1'b1;
            cd_x     = {az_q[15:0], 10'd0};
            cd_y     = {ay_q[15:0], 10'd0};
            state_d  = S_CORD_A;
          end else begin
            hemi_end = 1'b1;
          end
        end
      end
      S_CORD_A: begin
        if (cd_res.done) state_d = S_IDX_P;
      end
      S_IDX_P: state_d = S_IDX_A;
      S_IDX_A: state_d = S_IDX_C;
      S_IDX_C: state_d = S_MEM_RD;
      S_MEM_RD: state_d = S_MEM_WR;
      S_MEM_WR: hemi_end = 1'b1;
      S_RD_REQ: state_d = S_RD_OUT;
      S_RD_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    // go on with the rear hemisphere or finish
    if (hemi_end) begin
      if (rear_pend_q) begin
        load_rear = 1'b1;
        state_d   = S_MUL_X;
      end else begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      hemi_q      <= 1'b0;
      rear_pend_q <= 1'b0;
      ptr_q       <= '0;
      clr_q       <= '0;
      done_o      <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == S_RD_OUT);
      if (state_q == S_CLEAR) clr_q <= clr_q + ADDR_W'(1);
      if (load_front) begin
        hemi_q      <= 1'b0;
        rear_pend_q <= (bx < 0);
      end else if (load_rear_acc || load_rear) begin
        hemi_q      <= 1'b1;
        rear_pend_q <= 1'b0;
      end
      if (state_q == S_RD_OUT) begin
        ptr_q <= (ptr_q == ADDR_W'(TOTAL - 1)) ? '0 : ptr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rear_x_q <= -bx;
      rear_y_q <= -by;
      rear_z_q <= bz;
    end
    if (load_front) begin
      ax_q <= fx;
      ay_q <= fy;
      az_q <= fz;
    end else if (load_rear_acc) begin
      ax_q <= -bx;
      ay_q <= -by;
      az_q <= bz;
    end else if (load_rear) begin
      ax_q <= rear_x_q;
      ay_q <= rear_y_q;
      az_q <= rear_z_q;
    end
    unique case (state_q)
      S_MUL_Y: s_q <= prod_lo;
      S_MUL_Z: begin
        s_q  <= s_q + prod_lo;
        ps_q <= prod_lo;
      end
      S_MUL_N: begin
        s_q  <= s_q + prod_lo;
        ps_q <= ps_q + prod_lo;
      end
      S_MUL_F: lim_q <= prod[LIM_W*2-1:0];
      S_SQRT_R: begin
        if (sq_res.done) begin
          range_q <= sq_res.root[LIM_W-1:0] + LIM_W'(range_up);
        end
      end
      S_CORD_P: begin
        if (cd_res.done) polar_q <= (cd_res.ang < 0) ? '0 : cd_res.ang;
      end
      S_CORD_A: begin
        if (cd_res.done) azim_q <= (azim_sum < 0) ? '0 : azim_sum;
      end
      S_IDX_A: pi_q <= pi_d;
      S_IDX_C: addr_q <= addr_d;
      S_RD_OUT: begin
        bin_index_o <= 10'(32'(ptr_q));
        depth_mm_o  <= rd_depth;
        last_o      <= (ptr_q == ADDR_W'(TOTAL - 1));
      end
      default: ;
    endcase
  end

  // bin memory: forward cells first, then rear
  logic [LIM_W-1:0]  bins_q [TOTAL];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, rd_addr;
  logic [LIM_W-1:0]  mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = range_q;
    rd_addr   = (state_q == S_RD_REQ) ? ptr_q : addr_q;
    priority if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = FAR_RESET;
    end else if (state_q == S_RD_OUT) begin
      mem_we    = 1'b1;
      mem_waddr = ptr_q;
      mem_wdata = far_q;
    end else if (state_q == S_MEM_WR) begin
      mem_we = (range_q < rdata_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) bins_q[mem_waddr] <= mem_wdata;
    rdata_q <= bins_q[rd_addr];
  end

  a_done_from_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_RD_OUT))
    else $error("result strobe without a readout");

  a_last_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (last_o == (bin_index_o == 10'(TOTAL - 1))))
    else $error("last flag off the final bin");

  a_sqrt_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_res.done |-> (state_q == S_SQRT_R || state_q == S_SQRT_P))
    else $error("square root finished outside its wait states");

  a_cordic_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cd_res.done |-> (state_q == S_CORD_P || state_q == S_CORD_A))
    else $error("CORDIC finished outside its wait states");

  a_clear_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> (state_q == S_CLEAR || state_q == S_IDLE))
    else $error("clearing pass left early");

endmodule

// ----- tb/sv/hemisphere_lidar_min_depth_binner_tb.sv -----
// Self-checking testbench for the hemisphere lidar min-depth binner.
// Predicts every bin readout with its own integer CORDIC and square-root model.
// Depends on hlmdb_pkg and the hemisphere_lidar_min_depth_binner top level.
module hemisphere_lidar_min_depth_binner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hlmdb_pkg::*;

  localparam int  N_POLAR    = 16;
  localparam int  N_AZIM     = 31;
  localparam int  N_CELLS    = N_POLAR * N_AZIM;
  localparam int  N_FLAT     = 2 * N_CELLS;
  localparam int  SETTLE     = 250;
  localparam int  CYCLE_CAP  = 1000000;
  localparam bit  FUNC_ACCUM = 1'b0;
  localparam bit  FUNC_READ  = 1'b1;

  typedef struct {
    logic [9:0]       bin;
    logic [LIM_W-1:0] depth;
    logic             last;
  } bin_read_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      func_i = 1'b0;
  logic signed [COORD_W-1:0] x_mm_i = '0;
  logic signed [COORD_W-1:0] y_mm_i = '0;
  logic signed [COORD_W-1:0] z_mm_i = '0;
  logic                      done_o;
  logic [9:0]                bin_index_o;
  logic [LIM_W-1:0]          depth_mm_o;
  logic                      last_o;
  logic                      cfg_we_i = 1'b0;
  logic [2:0]                cfg_idx_i = '0;
  logic [OFF_W-1:0]          cfg_wdata_i = '0;

  // predictor state
  logic signed [OFF_W-1:0] sensor_off [6];
  logic [LIM_W-1:0]        near_mm, far_mm;
  logic [LIM_W-1:0]        front_depth [N_CELLS];
  logic [LIM_W-1:0]        rear_depth [N_CELLS];
  int                      read_ptr;

  bin_read_t readout_q[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        gaps_on = 1'b1;
  int        burst_left = 0;

  always #1 clk_i = ~clk_i;

  hemisphere_lidar_min_depth_binner u_top (
    .clk_i, .rst_ni, .start, .busy, .func_i, .x_mm_i, .y_mm_i, .z_mm_i,
    .done_o, .bin_index_o, .depth_mm_o, .last_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring rotation, x >= 0; angle in 2^-24 turn
  function automatic longint vector_angle(longint x, longint y);
    longint ang, sx, sy;
    ang = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (y >= 0) begin
        x = x + sx; y = y - sy; ang = ang + ATAN_TAB[i];
      end else begin
        x = x - sx; y = y + sy; ang = ang - ATAN_TAB[i];
      end
    end
    return ang;
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint half;
    half = longint'(HALF_TURN);
    if (y == 0) return (x < 0) ? half : 0;
    if (x < 0) return ((y > 0) ? half : -half) + vector_angle(-x, -y);
    return vector_angle(x, y);
  endfunction

  function automatic void bin_hit(bit rear, longint ax, longint ay, longint az, longint axis);
    longint s, ps, r, perp, polar, azim, pi, ai, nl, fl;
    int idx;
    nl = near_mm;
    fl = far_mm;
    s = ax * ax + ay * ay + az * az;
    ps = ay * ay + az * az;
    if (s < nl * nl || s > fl * fl) return;
    r = longint'(int_sqrt(s));
    if (s - r * r > r) r++;
    perp = longint'(int_sqrt(ps << 20));
    polar = angle_of(perp, axis * 1024);
    if (polar > longint'(POLAR_MAX)) return;
    if (polar < 0) polar = 0;
    azim = angle_of(ay * 1024, az * 1024) + longint'(HALF_TURN);
    if (azim < 0) azim = 0;
    pi = (9 * polar * (N_POLAR - 1) + (64'sd1 << 24)) >>> 25;
    ai = (azim * (N_AZIM - 1) + longint'(HALF_TURN)) >>> 24;
    if (pi > N_POLAR - 1) pi = N_POLAR - 1;
    if (ai > N_AZIM - 1) ai = N_AZIM - 1;
    idx = int'(pi * N_AZIM + ai);
    if (rear) begin
      if (r < rear_depth[idx]) rear_depth[idx] = LIM_W'(r);
    end else begin
      if (r < front_depth[idx]) front_depth[idx] = LIM_W'(r);
    end
  endfunction

  function automatic void predict_point(longint px, longint py, longint pz);
    longint fx, fy, fz, bx, by, bz;
    fx = px - sensor_off[REG_FRONT_X];
    fy = py - sensor_off[REG_FRONT_Y];
    fz = pz - sensor_off[REG_FRONT_Z];
    bx = px - sensor_off[REG_REAR_X];
    by = py - sensor_off[REG_REAR_Y];
    bz = pz - sensor_off[REG_REAR_Z];
    if (fx > 0) bin_hit(1'b0, fx, fy, fz, fx);
    if (bx < 0) bin_hit(1'b1, bx, -by, bz, -bx);
  endfunction

  function automatic void predict_readout();
    bin_read_t e;
    logic [LIM_W-1:0] d;
    d = (read_ptr < N_CELLS) ? front_depth[read_ptr] : rear_depth[read_ptr - N_CELLS];
    if (d < near_mm) d = far_mm;
    if (read_ptr < N_CELLS) front_depth[read_ptr] = far_mm;
    else rear_depth[read_ptr - N_CELLS] = far_mm;
    e.bin = 10'(read_ptr);
    e.depth = d;
    e.last = (read_ptr == N_FLAT - 1);
    readout_q.push_back(e);
    read_ptr = (read_ptr + 1) % N_FLAT;
  endfunction

  // result checker: no back-pressure, sample every edge
  always @(posedge clk_i) begin
    bin_read_t e;
    if (rst_ni && done_o) begin
      if (readout_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: bin %0d depth %0d last %0b",
                   bin_index_o, depth_mm_o, last_o);
        mismatches++;
      end else begin
        e = readout_q.pop_front();
        if (bin_index_o !== e.bin || depth_mm_o !== e.depth || last_o !== e.last) begin
          if (mismatches < 10)
            $display("mismatch: exp bin %0d depth %0d last %0b, got bin %0d depth %0d last %0b",
                     e.bin, e.depth, e.last, bin_index_o, depth_mm_o, last_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("hemisphere_lidar_min_depth_binner test failed");
      $finish;
    end
  end

  task automatic send(bit f, int x, int y, int z);
    int gap;
    start <= 1'b1;
    func_i <= f;
    x_mm_i <= COORD_W'(x);
    y_mm_i <= COORD_W'(y);
    z_mm_i <= COORD_W'(z);
    do @(posedge clk_i); while (busy);
    if (f == FUNC_READ) predict_readout();
    else predict_point(longint'(COORD_W'(x)) <<< 44 >>> 44,
                       longint'(COORD_W'(y)) <<< 44 >>> 44,
                       longint'(COORD_W'(z)) <<< 44 >>> 44);
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 16);
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  // hold off until all readouts are back, then let a point in flight finish
  task automatic drain();
    start <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, int value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= OFF_W'(value);
    @(posedge clk_i);
    if (idx == REG_NEAR) near_mm = LIM_W'(value);
    else if (idx == REG_FAR) far_mm = LIM_W'(value);
    else sensor_off[idx] = OFF_W'(value);
  endtask

  task automatic set_config(int fx, int fy, int fz, int rx, int ry, int rz, int nl, int fl);
    drain();
    write_reg(REG_FRONT_X, fx);
    write_reg(REG_FRONT_Y, fy);
    write_reg(REG_FRONT_Z, fz);
    write_reg(REG_REAR_X, rx);
    write_reg(REG_REAR_Y, ry);
    write_reg(REG_REAR_Z, rz);
    write_reg(REG_NEAR, nl);
    write_reg(REG_FAR, fl);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int rand_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic test_directed_points();
    send(FUNC_ACCUM, 524287, 524287, 524287);
    send(FUNC_ACCUM, -524288, -524288, -524288);
    send(FUNC_ACCUM, 0, 0, 0);
    send(FUNC_ACCUM, 320, 0, -13);          // on the front origin
    send(FUNC_ACCUM, 1320, 0, -13);         // straight ahead
    send(FUNC_ACCUM, -1320, 0, -13);        // straight behind
    send(FUNC_ACCUM, 620, 0, -13);          // exactly at near range
    send(FUNC_ACCUM, 2820, 0, -13);         // exactly at far range
    send(FUNC_ACCUM, 2821, 0, -13);         // just beyond far
    send(FUNC_ACCUM, 500, 0, -800);         // azimuth half turn
    send(FUNC_ACCUM, 500, 900, -13);        // steep polar, just inside the limit
    send(FUNC_ACCUM, 700, -600, 400);
    send(FUNC_ACCUM, -700, 600, -500);
    send(FUNC_ACCUM, 340, 5, -13);
    send(FUNC_ACCUM, 0, 1000, 0);
    for (int i = 0; i < 6; i++) send(FUNC_READ, 0, 0, 0);
  endtask

  // raise near above stored hits and shrink far so cleared bins refill differently
  task automatic test_blind_zone();
    set_config(320, 0, -13, -320, 0, -13, 300, 2500);
    send(FUNC_ACCUM, 820, 0, -13);
    send(FUNC_ACCUM, -1020, 0, -13);
    send(FUNC_ACCUM, 1000, 300, 200);
    set_config(320, 0, -13, -320, 0, -13, 1000, 1200);
  endtask

  task automatic test_frame_end();
    while (read_ptr != 0) send(FUNC_READ, $urandom, $urandom, $urandom);
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) send(FUNC_ACCUM, rand_span(2000), rand_span(2000), rand_span(2000));
      else if (r < 50) send(FUNC_ACCUM, rand_span(4500), rand_span(4500), rand_span(4500));
      else if (r < 55) send(FUNC_ACCUM, $urandom, $urandom, $urandom);
      else send(FUNC_READ, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_random_configs();
    set_config(rand_span(500), rand_span(500), rand_span(500),
               rand_span(500), rand_span(500), rand_span(500),
               $urandom_range(0, 600), $urandom_range(1500, 4095));
    test_random(40);
    set_config(4095, 4095, 4095, -4096, -4096, -4096, 0, 4095);
    test_random(30);
    set_config(-4096, -4096, -4096, 4095, 4095, 4095, 4095, 0);
    test_random(25);
    set_config(0, 0, 0, 0, 0, 0, 0, 4095);
    gaps_on = 1'b0;
    test_random(40);
    gaps_on = 1'b1;
    set_config(rand_span(4096), rand_span(4096), rand_span(4096),
               rand_span(4096), rand_span(4096), rand_span(4096),
               $urandom_range(0, 4095), $urandom_range(0, 4095));
    test_random(25);
    set_config(rand_span(300), rand_span(300), rand_span(300),
               rand_span(300), rand_span(300), rand_span(300),
               $urandom_range(0, 400), $urandom_range(2000, 4095));
    test_random(40);
  endtask

  initial begin
    sensor_off[REG_FRONT_X] = 320;
    sensor_off[REG_FRONT_Y] = 0;
    sensor_off[REG_FRONT_Z] = -13;
    sensor_off[REG_REAR_X] = -320;
    sensor_off[REG_REAR_Y] = 0;
    sensor_off[REG_REAR_Z] = -13;
    near_mm = 300;
    far_mm = FAR_RESET;
    for (int i = 0; i < N_CELLS; i++) begin
      front_depth[i] = FAR_RESET;
      rear_depth[i] = FAR_RESET;
    end
    read_ptr = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_points();
    test_blind_zone();
    test_random_configs();
    test_frame_end();

    drain();
    if (mismatches == 0) begin
      $display("hemisphere_lidar_min_depth_binner test passed");
    end else begin
      $display("hemisphere_lidar_min_depth_binner test failed");
    end
    $finish;
  end

endmodule
